// File: rtl/core/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds at every edge outside reset.
`define AST_HOLD(name, clk, rst_n, pexpr, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pexpr)) else $error(msg);

// Antecedent at one edge implies consequent at the next edge.
`define AST_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/hsc_pkg.sv
package hsc_pkg;

    localparam int unsigned DATA_W  = 32;
    localparam int unsigned GAIN_W  = 31;
    localparam int unsigned COEF_W  = 26;
    localparam int unsigned OPND_W  = 33;
    localparam int unsigned ACC_W   = 2 * OPND_W;
    localparam int unsigned STEP_W  = 6;
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(50);

    localparam logic [GAIN_W-1:0] FF_GAIN_RST = GAIN_W'(65536);
    localparam logic [GAIN_W-1:0] NL_GAIN_RST = GAIN_W'(22938);

    typedef enum logic {
        REG_FF_GAIN = 1'b0,
        REG_NL_GAIN = 1'b1
    } cfg_reg_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MUL,
        S_ACC,
        S_DONE
    } seq_state_t;

    typedef enum logic [1:0] {
        A_COEF,
        A_FF,
        A_NL,
        A_NEGT
    } a_sel_t;

    typedef enum logic [4:0] {
        V_X0, V_X1, V_X2, V_X3, V_X4,
        V_K0, V_K1,
        V_NX0, V_NX1, V_NX2, V_NX3, V_NX4,
        V_NK0, V_NK1,
        V_ERR, V_MEAS, V_MOTOR, V_ANGLE, V_RATE, V_TV, V_CTRL
    } slot_t;

    localparam int unsigned NUM_SLOTS = 21;

    typedef struct packed {
        a_sel_t                    a_sel;
        logic signed [COEF_W-1:0]  coef;
        slot_t                     b;
        logic                      absb;
        logic                      first;
        logic                      last;
        slot_t                     dst;
    } step_t;

    typedef struct packed {
        logic mul_en;
        logic acc_en;
        logic finish;
        logic busy;
    } seq_ctl_t;

    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [DATA_W:0] v);
        logic signed [DATA_W-1:0] r;
        if (v[DATA_W] != v[DATA_W-1])
            r = v[DATA_W] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
        else
            r = v[DATA_W-1:0];
        return r;
    endfunction

    // add half LSB, floor shift by 16, clamp to 32 bits
    function automatic logic signed [DATA_W-1:0] round_sat(input logic signed [ACC_W-1:0] s);
        logic signed [ACC_W-1:0] t;
        logic signed [ACC_W-1:0] q;
        logic signed [DATA_W-1:0] r;
        t = s + ACC_W'(32768);
        q = t >>> 16;
        if (q > ACC_W'(64'sd2147483647))
            r = {1'b0, {(DATA_W-1){1'b1}}};
        else if (q < -ACC_W'(64'sd2147483648))
            r = {1'b1, {(DATA_W-1){1'b0}}};
        else
            r = q[DATA_W-1:0];
        return r;
    endfunction

    function automatic step_t st(input a_sel_t a, input int c, input slot_t b,
                                 input logic ab, input logic f, input logic l,
                                 input slot_t d);
        step_t s;
        s.a_sel = a;
        s.coef  = COEF_W'(c);
        s.b     = b;
        s.absb  = ab;
        s.first = f;
        s.last  = l;
        s.dst   = d;
        return s;
    endfunction

    // microcode: one product per step
    function automatic step_t step_rom(input logic [STEP_W-1:0] idx);
        step_t s;
        case (idx)
            // controller rows: B*err + A*x
            6'd0:  s = st(A_COEF,   16345, V_ERR, 1'b0, 1'b1, 1'b0, V_NX0);
            6'd1:  s = st(A_COEF,   19163, V_X0,  1'b0, 1'b0, 1'b0, V_NX0);
            6'd2:  s = st(A_COEF,   87333, V_X1,  1'b0, 1'b0, 1'b0, V_NX0);
            6'd3:  s = st(A_COEF, -287900, V_X2,  1'b0, 1'b0, 1'b0, V_NX0);
            6'd4:  s = st(A_COEF,  262485, V_X3,  1'b0, 1'b0, 1'b0, V_NX0);
            6'd5:  s = st(A_COEF,   20598, V_X4,  1'b0, 1'b0, 1'b1, V_NX0);
            6'd6:  s = st(A_COEF,   -2038, V_ERR, 1'b0, 1'b1, 1'b0, V_NX1);
            6'd7:  s = st(A_COEF,    -767, V_X0,  1'b0, 1'b0, 1'b0, V_NX1);
            6'd8:  s = st(A_COEF,   52455, V_X1,  1'b0, 1'b0, 1'b0, V_NX1);
            6'd9:  s = st(A_COEF,   43785, V_X2,  1'b0, 1'b0, 1'b0, V_NX1);
            6'd10: s = st(A_COEF,  -36851, V_X3,  1'b0, 1'b0, 1'b0, V_NX1);
            6'd11: s = st(A_COEF,   -3002, V_X4,  1'b0, 1'b0, 1'b1, V_NX1);
            6'd12: s = st(A_COEF,  -13487, V_ERR, 1'b0, 1'b1, 1'b0, V_NX2);
            6'd13: s = st(A_COEF,    -963, V_X0,  1'b0, 1'b0, 1'b0, V_NX2);
            6'd14: s = st(A_COEF,   11574, V_X1,  1'b0, 1'b0, 1'b0, V_NX2);
            6'd15: s = st(A_COEF,   29373, V_X2,  1'b0, 1'b0, 1'b0, V_NX2);
            6'd16: s = st(A_COEF,    8297, V_X3,  1'b0, 1'b0, 1'b0, V_NX2);
            6'd17: s = st(A_COEF,    1442, V_X4,  1'b0, 1'b0, 1'b1, V_NX2);
            6'd18: s = st(A_COEF,   -6776, V_ERR, 1'b0, 1'b1, 1'b0, V_NX3);
            6'd19: s = st(A_COEF,     164, V_X0,  1'b0, 1'b0, 1'b0, V_NX3);
            6'd20: s = st(A_COEF,    2241, V_X1,  1'b0, 1'b0, 1'b0, V_NX3);
            6'd21: s = st(A_COEF,   -2372, V_X2,  1'b0, 1'b0, 1'b0, V_NX3);
            6'd22: s = st(A_COEF,   20441, V_X3,  1'b0, 1'b0, 1'b0, V_NX3);
            6'd23: s = st(A_COEF,   -2038, V_X4,  1'b0, 1'b0, 1'b1, V_NX3);
            6'd24: s = st(A_COEF,      39, V_ERR, 1'b0, 1'b1, 1'b0, V_NX4);
            6'd25: s = st(A_COEF,      26, V_X0,  1'b0, 1'b0, 1'b0, V_NX4);
            6'd26: s = st(A_COEF,       0, V_X1,  1'b0, 1'b0, 1'b0, V_NX4);
            6'd27: s = st(A_COEF,      13, V_X2,  1'b0, 1'b0, 1'b0, V_NX4);
            6'd28: s = st(A_COEF,   -1986, V_X3,  1'b0, 1'b0, 1'b0, V_NX4);
            6'd29: s = st(A_COEF,   65418, V_X4,  1'b0, 1'b0, 1'b1, V_NX4);
            // motor force C*x'
            6'd30: s = st(A_COEF,   -961996, V_NX0, 1'b0, 1'b1, 1'b0, V_MOTOR);
            6'd31: s = st(A_COEF,   3257015, V_NX1, 1'b0, 1'b0, 1'b0, V_MOTOR);
            6'd32: s = st(A_COEF, -11557863, V_NX2, 1'b0, 1'b0, 1'b0, V_MOTOR);
            6'd33: s = st(A_COEF,  17062501, V_NX3, 1'b0, 1'b0, 1'b0, V_MOTOR);
            6'd34: s = st(A_COEF,   1133399, V_NX4, 1'b0, 1'b0, 1'b1, V_MOTOR);
            // observer
            6'd35: s = st(A_COEF, 58071, V_K0,    1'b0, 1'b1, 1'b0, V_NK0);
            6'd36: s = st(A_COEF, -1619, V_K1,    1'b0, 1'b0, 1'b0, V_NK0);
            6'd37: s = st(A_COEF,  7465, V_MOTOR, 1'b0, 1'b0, 1'b0, V_NK0);
            6'd38: s = st(A_COEF,  1619, V_MEAS,  1'b0, 1'b0, 1'b1, V_NK0);
            6'd39: s = st(A_COEF,  6173, V_K0,    1'b0, 1'b1, 1'b0, V_NK1);
            6'd40: s = st(A_COEF, 60568, V_K1,    1'b0, 1'b0, 1'b0, V_NK1);
            6'd41: s = st(A_COEF,   380, V_MOTOR, 1'b0, 1'b0, 1'b0, V_NK1);
            6'd42: s = st(A_COEF,  4968, V_MEAS,  1'b0, 1'b0, 1'b1, V_NK1);
            // angle and rate
            6'd43: s = st(A_COEF, 60739, V_NK1,  1'b0, 1'b1, 1'b0, V_ANGLE);
            6'd44: s = st(A_COEF,  4797, V_MEAS, 1'b0, 1'b0, 1'b1, V_ANGLE);
            6'd45: s = st(A_COEF, 65536, V_NK0,  1'b0, 1'b1, 1'b0, V_RATE);
            6'd46: s = st(A_COEF, -1828, V_NK1,  1'b0, 1'b0, 1'b0, V_RATE);
            6'd47: s = st(A_COEF,  1828, V_MEAS, 1'b0, 1'b0, 1'b1, V_RATE);
            // compensation
            6'd48: s = st(A_NL,   0, V_ANGLE, 1'b1, 1'b1, 1'b1, V_TV);
            6'd49: s = st(A_FF,   0, V_ANGLE, 1'b0, 1'b1, 1'b0, V_CTRL);
            6'd50: s = st(A_NEGT, 0, V_ANGLE, 1'b0, 1'b0, 1'b1, V_CTRL);
            default: s = st(A_COEF, 0, V_ERR, 1'b0, 1'b1, 1'b1, V_CTRL);
        endcase
        return s;
    endfunction

endpackage

// File: rtl/core/hsc_mac.sv
module hsc_mac (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 mul_en,
    input  logic                                 acc_en,
    input  logic                                 first,
    input  logic signed [hsc_pkg::OPND_W-1:0]    a,
    input  logic signed [hsc_pkg::OPND_W-1:0]    b,
    output logic signed [hsc_pkg::DATA_W-1:0]    result
);
    import hsc_pkg::*;

    logic signed [ACC_W-1:0] prod_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [ACC_W-1:0] acc_next;

    assign acc_next = first ? prod_reg : acc_reg + prod_reg;
    assign result   = round_sat(acc_next);

    always_ff @(posedge clk)
    begin
        if (mul_en)
        begin
            prod_reg <= a * b;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
        end
        else if (acc_en)
        begin
            acc_reg <= acc_next;
        end
    end

endmodule

// File: rtl/core/hsc_seq.sv
module hsc_seq (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic                          out_free,
    output logic [hsc_pkg::STEP_W-1:0]    step_idx,
    output hsc_pkg::seq_ctl_t             ctl
);
    import hsc_pkg::*;

    seq_state_t          state_reg, state_next;
    logic [STEP_W-1:0]   step_reg, step_next;

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_MUL;
                    step_next  = '0;
                end
            end
            S_MUL:
            begin
                state_next = S_ACC;
            end
            S_ACC:
            begin
                if (step_reg == LAST_STEP)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_MUL;
                    step_next  = step_reg + 1'b1;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        ctl.mul_en = (state_reg == S_MUL);
        ctl.acc_en = (state_reg == S_ACC);
        ctl.finish = (state_reg == S_DONE) && out_free;
        ctl.busy   = (state_reg != S_IDLE);
    end

    assign step_idx = step_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

endmodule

// File: rtl/core/state_space_heading_controller.sv
// Heading controller: each transfer on the input channel carries a measured and a target
// yaw (signed Q16.16) and yields one result transfer with the compensated angle
// (control_value), the controller output (motor_force) and the observer rate estimate.
// All 51 products of one update go through a single 33x33 multiplier and one
// accumulator under a microcoded sequencer, a multiply state then an accumulate
// state per product; in_stall is high from the input transfer until the sequencer
// is back in idle. A finished result sits in an output register, so the next item
// can be taken while the result is still stalled. Gains are written over the cfg
// port and must only change while the block is idle.
module state_space_heading_controller (
    input  logic                                clk,
    input  logic                                rst_n,
    // input channel
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic signed [hsc_pkg::DATA_W-1:0]   yaw_measured,
    input  logic signed [hsc_pkg::DATA_W-1:0]   yaw_target,
    // result channel
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [hsc_pkg::DATA_W-1:0]   control_value,
    output logic signed [hsc_pkg::DATA_W-1:0]   motor_force,
    output logic signed [hsc_pkg::DATA_W-1:0]   rate_estimate,
    // configuration
    input  logic                                cfg_we,
    input  logic                                cfg_index,
    input  logic [hsc_pkg::GAIN_W-1:0]          cfg_data
);
    import hsc_pkg::*;

    logic [GAIN_W-1:0]        ff_gain_reg;
    logic [GAIN_W-1:0]        nl_gain_reg;
    logic signed [DATA_W-1:0] val_reg [NUM_SLOTS];
    logic                     out_valid_reg;
    logic signed [DATA_W-1:0] ctrl_reg, motor_reg, rate_reg;

    logic                     in_xfer;
    logic                     out_free;
    logic [STEP_W-1:0]        step_idx;
    seq_ctl_t                 ctl;
    step_t                    step;
    logic signed [DATA_W-1:0] b_raw;
    logic signed [OPND_W-1:0] opnd_a, opnd_b;
    logic signed [DATA_W-1:0] mac_result;
    logic signed [DATA_W-1:0] err;

    assign in_stall = ctl.busy;
    assign in_xfer  = in_valid && !ctl.busy;
    // output register is free when empty or being drained this cycle
    assign out_free = !out_valid_reg || !out_stall;

    // error at 33 bits, clamped to 32
    assign err = sat32({yaw_target[DATA_W-1], yaw_target}
                       - {yaw_measured[DATA_W-1], yaw_measured});

    hsc_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (in_xfer),
        .out_free (out_free),
        .step_idx (step_idx),
        .ctl      (ctl)
    );

    assign step  = step_rom(step_idx);
    assign b_raw = val_reg[step.b];

    // B operand: value from the scratch file, optionally magnitude
    always_comb
    begin
        opnd_b = {b_raw[DATA_W-1], b_raw};
        if (step.absb && b_raw[DATA_W-1])
        begin
            opnd_b = -opnd_b;
        end
    end

    // A operand: ROM coefficient, a gain, or minus the quadratic term
    always_comb
    begin
        case (step.a_sel)
            A_COEF:  opnd_a = {{(OPND_W-COEF_W){step.coef[COEF_W-1]}}, step.coef};
            A_FF:    opnd_a = {{(OPND_W-GAIN_W){1'b0}}, ff_gain_reg};
            A_NL:    opnd_a = {{(OPND_W-GAIN_W){1'b0}}, nl_gain_reg};
            A_NEGT:  opnd_a = -{val_reg[V_TV][DATA_W-1], val_reg[V_TV]};
            default: opnd_a = '0;
        endcase
    end

    hsc_mac u_mac (
        .clk    (clk),
        .rst_n  (rst_n),
        .mul_en (ctl.mul_en),
        .acc_en (ctl.acc_en),
        .first  (step.first),
        .a      (opnd_a),
        .b      (opnd_b),
        .result (mac_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ff_gain_reg <= FF_GAIN_RST;
            nl_gain_reg <= NL_GAIN_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_FF_GAIN: ff_gain_reg <= cfg_data;
                REG_NL_GAIN: nl_gain_reg <= cfg_data;
                default:     ff_gain_reg <= ff_gain_reg;
            endcase
        end
    end

    // scratch file; controller and observer states live in the first slots
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_SLOTS; i++)
            begin
                val_reg[i] <= '0;
            end
        end
        else
        begin
            if (in_xfer)
            begin
                val_reg[V_ERR]  <= err;
                val_reg[V_MEAS] <= yaw_measured;
            end
            if (ctl.acc_en && step.last)
            begin
                val_reg[step.dst] <= mac_result;
            end
            if (ctl.finish)
            begin
                val_reg[V_X0] <= val_reg[V_NX0];
                val_reg[V_X1] <= val_reg[V_NX1];
                val_reg[V_X2] <= val_reg[V_NX2];
                val_reg[V_X3] <= val_reg[V_NX3];
                val_reg[V_X4] <= val_reg[V_NX4];
                val_reg[V_K0] <= val_reg[V_NK0];
                val_reg[V_K1] <= val_reg[V_NK1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ctl.finish)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.finish)
        begin
            ctrl_reg  <= val_reg[V_CTRL];
            motor_reg <= val_reg[V_MOTOR];
            rate_reg  <= val_reg[V_RATE];
        end
    end

    assign out_valid     = out_valid_reg;
    assign control_value = ctrl_reg;
    assign motor_force   = motor_reg;
    assign rate_estimate = rate_reg;

endmodule

// File: rtl/core/hsc_checker.sv
`include "assert_macros.svh"

module hsc_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                in_valid,
    input logic                                in_stall,
    input logic                                out_valid,
    input logic                                out_stall,
    input logic signed [hsc_pkg::DATA_W-1:0]   control_value,
    input logic signed [hsc_pkg::DATA_W-1:0]   motor_force,
    input logic signed [hsc_pkg::DATA_W-1:0]   rate_estimate
);
    import hsc_pkg::*;

    // a transfer in starts work, so the input side stalls next cycle
    `AST_NEXT(a_busy_after_in, clk, rst_n, in_valid && !in_stall, in_stall, "not busy after transfer")

    // a new result only appears at the end of work
    `AST_HOLD(a_result_from_work, clk, rst_n, !$rose(out_valid) || $past(in_stall), "result without work")

    // a stalled result holds its payload
    `AST_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(control_value) && $stable(motor_force) && $stable(rate_estimate), "stalled result changed")

endmodule

bind state_space_heading_controller hsc_checker u_hsc_checker (.*);

// File: tb/state_space_heading_controller_test.sv
`timescale 1ns / 1ps

// Self-checking bench for the heading controller: a bit-accurate predictor of the
// controller, observer and compensation stages feeds a queue of expected results;
// every output transfer is checked against the oldest entry.
module state_space_heading_controller_test;
    import hsc_pkg::*;

    typedef struct {
        logic signed [31:0] ctrl;
        logic signed [31:0] motor;
        logic signed [31:0] rate;
    } heading_result_t;

    int error_count = 0;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    class heading_scoreboard;
        heading_result_t pending[$];
        longint ff_gain;
        longint nl_gain;
        longint cx[5];
        longint ok[2];
        longint coef_a[5][5];
        longint coef_b[5];
        longint coef_c[5];

        function new();
            coef_a = '{'{19163, 87333, -287900, 262485, 20598},
                       '{-767, 52455, 43785, -36851, -3002},
                       '{-963, 11574, 29373, 8297, 1442},
                       '{164, 2241, -2372, 20441, -2038},
                       '{26, 0, 13, -1986, 65418}};
            coef_b = '{16345, -2038, -13487, -6776, 39};
            coef_c = '{-961996, 3257015, -11557863, 17062501, 1133399};
            ff_gain = 65536;
            nl_gain = 22938;
            foreach (cx[i]) cx[i] = 0;
            ok[0] = 0;
            ok[1] = 0;
        endfunction

        function longint clamp32(input longint v);
            if (v > 64'sd2147483647) return 64'sd2147483647;
            if (v < -64'sd2147483648) return -64'sd2147483648;
            return v;
        endfunction

        // 128-bit sum avoids overflow on large compensation products
        function longint rnd(input logic signed [127:0] s);
            logic signed [127:0] q;
            q = (s + 128'sd32768) >>> 16;
            if (q > 128'sd2147483647) return 64'sd2147483647;
            if (q < -128'sd2147483648) return -64'sd2147483648;
            return longint'(q);
        endfunction

        function void note_input(input logic signed [31:0] meas_in,
                                 input logic signed [31:0] targ_in);
            longint meas, err, nx[5], nk[2], motor, angle, mag, t;
            logic signed [127:0] acc;
            heading_result_t r;
            meas = meas_in;
            err = clamp32(longint'(targ_in) - meas);
            for (int i = 0; i < 5; i++)
            begin
                acc = coef_b[i] * err;
                for (int j = 0; j < 5; j++) acc += coef_a[i][j] * cx[j];
                nx[i] = rnd(acc);
            end
            acc = 0;
            for (int i = 0; i < 5; i++)
            begin
                cx[i] = nx[i];
                acc += coef_c[i] * nx[i];
            end
            motor = rnd(acc);
            nk[0] = rnd(58071 * ok[0] - 1619 * ok[1] + 7465 * motor + 1619 * meas);
            nk[1] = rnd(6173 * ok[0] + 60568 * ok[1] + 380 * motor + 4968 * meas);
            ok[0] = nk[0];
            ok[1] = nk[1];
            angle = rnd(60739 * nk[1] + 4797 * meas);
            r.rate = 32'(rnd(65536 * nk[0] - 1828 * nk[1] + 1828 * meas));
            mag = angle < 0 ? -angle : angle;
            t = rnd(128'(nl_gain) * mag);
            acc = 128'(ff_gain) * angle - 128'(t) * angle;
            r.ctrl = 32'(rnd(acc));
            r.motor = 32'(motor);
            pending.push_back(r);
        endfunction

        task check_result(input logic signed [31:0] c, input logic signed [31:0] m,
                          input logic signed [31:0] rt);
            heading_result_t e;
            if (pending.size() == 0)
            begin
                report_mismatch("unexpected transfer", c, 0);
                return;
            end
            e = pending.pop_front();
            if (c !== e.ctrl) report_mismatch("control_value", c, e.ctrl);
            if (m !== e.motor) report_mismatch("motor_force", m, e.motor);
            if (rt !== e.rate) report_mismatch("rate_estimate", rt, e.rate);
        endtask
    endclass

    logic clk = 0;
    logic rst_n = 0;
    logic in_valid = 0;
    logic in_stall;
    logic signed [31:0] yaw_measured = 0;
    logic signed [31:0] yaw_target = 0;
    logic out_valid;
    logic out_stall = 0;
    logic signed [31:0] control_value, motor_force, rate_estimate;
    logic cfg_we = 0;
    logic cfg_index = 0;
    logic [GAIN_W-1:0] cfg_data = 0;

    heading_scoreboard sb = new();

    // idle percentages for each side, changed per phase
    int send_idle = 0;
    int recv_idle = 0;
    int long_hold = 0;   // cycles of forced receiver stall, counted below

    state_space_heading_controller uut (.*);

    initial
    begin
        forever #5 clk = ~clk;
    end

    // receiver: random stall plus an optional long hold-off
    always @(posedge clk)
    begin
        if (long_hold > 0)
        begin
            long_hold <= long_hold - 1;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(99) < recv_idle);
    end

    // result checking at the accepting edge
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_result(control_value, motor_force, rate_estimate);
    end

    // one input transfer; payload is held until accepted, valid drops only when idling
    task automatic send_item(input logic signed [31:0] meas, input logic signed [31:0] targ);
        while ($urandom_range(99) < send_idle)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        yaw_measured <= meas;
        yaw_target <= targ;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        sb.note_input(meas, targ);
    endtask

    // wait until all results are back, plus the block's latency
    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (150) @(posedge clk);
    endtask

    task automatic write_gain(input cfg_reg_t idx, input logic [GAIN_W-1:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_FF_GAIN) sb.ff_gain = val;
        else sb.nl_gain = val;
    endtask

    // mostly small, plausible headings with occasional full-range values
    function automatic logic signed [31:0] rand_yaw();
        case ($urandom_range(9))
            0: return $urandom;
            1: return $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
            default: return $signed($urandom_range(800000)) - 400000;
        endcase
    endfunction

    task automatic random_phase(input int n, input int si, input int ri);
        send_idle = si;
        recv_idle = ri;
        repeat (n) send_item(rand_yaw(), rand_yaw());
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: zero, extremes of both fields, error saturation both ways
        send_item(0, 0);
        send_item(32'sh7fffffff, 32'sh80000000);
        send_item(32'sh80000000, 32'sh7fffffff);
        send_item(32'sh7fffffff, 32'sh7fffffff);
        send_item(32'sh80000000, 32'sh80000000);
        send_item(32'shffffffff, 1);
        send_item(65536, -65536);
        send_item(0, 32'sh00100000);
        send_item(-123456, 654321);
        send_item(32'sh55555555, 32'shaaaaaaaa);
        drain();

        // gain extremes
        write_gain(REG_FF_GAIN, '1);
        write_gain(REG_NL_GAIN, '0);
        send_item(32'sh40000000, 0);
        send_item(0, 32'sh7fffffff);
        send_item(-1000000, 1000000);
        drain();
        write_gain(REG_FF_GAIN, '0);
        write_gain(REG_NL_GAIN, '1);
        send_item(32'sh7fffffff, 0);
        send_item(300000, -300000);
        send_item(32'sh80000000, 0);
        drain();
        write_gain(REG_FF_GAIN, GAIN_W'(65536));
        write_gain(REG_NL_GAIN, GAIN_W'(22938));

        random_phase(120, 0, 0);
        // long hold-off while the sender keeps offering
        long_hold = 600;
        random_phase(20, 0, 0);
        drain();   // sender pauses for all results
        write_gain(REG_FF_GAIN, GAIN_W'($urandom_range(200000)));
        write_gain(REG_NL_GAIN, GAIN_W'($urandom_range(100000)));
        random_phase(120, 81, 0);
        drain();
        write_gain(REG_FF_GAIN, GAIN_W'($urandom));
        write_gain(REG_NL_GAIN, GAIN_W'($urandom));
        random_phase(120, 0, 81);
        drain();
        write_gain(REG_FF_GAIN, GAIN_W'(65536));
        write_gain(REG_NL_GAIN, GAIN_W'(22938));
        random_phase(120, 31, 31);
        drain();

        if (error_count == 0 && sb.pending.size() == 0)
            $display("state_space_heading_controller test passed");
        else
            $display("state_space_heading_controller test failed");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("state_space_heading_controller test failed");
        $finish;
    end
endmodule
